// ===== rtl/mlc_pkg.sv =====
`timescale 1ns / 1ps

package mlc_pkg;

  // Fixed field widths
  localparam int ADDR_W    = 32;
  localparam int TAG_W     = 12;
  localparam int TAG_LSB   = 20;
  localparam int KIND_W    = 3;
  localparam int OUT_AGE_W = 4;

  // At most eight results per request; the queue keeps room for two requests
  localparam int MAX_RES   = 8;
  localparam int RES_DEPTH = 16;
  localparam int RES_PTR_W = 4;
  localparam int RES_CNT_W = 5;
  localparam int PUSH_W    = 4;

  // Register map: index taken from paddr[2]
  localparam logic REG_IDX_REPORT = 1'b0;

  typedef enum logic [2:0] {
    REQ_READ  = 3'd0,
    REQ_WRITE = 3'd1,
    REQ_FETCH = 3'd2,
    REQ_INVAL = 3'd3,
    REQ_SNOOP = 3'd4,
    REQ_CLEAR = 3'd5,
    REQ_DUMP  = 3'd6
  } req_kind_t;

  typedef enum logic [2:0] {
    MSG_NONE  = 3'd0,
    MSG_READ  = 3'd1,
    MSG_RFO   = 3'd2,
    MSG_WRITE = 3'd3,
    MSG_RDATA = 3'd4,
    MSG_IREAD = 3'd5,
    MSG_DUMP  = 3'd6
  } msg_kind_t;

  typedef enum logic [1:0] {
    MESI_M = 2'd0,
    MESI_E = 2'd1,
    MESI_S = 2'd2,
    MESI_I = 2'd3
  } mesi_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } ctrl_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ADDR_W-1:0]    addr;
    logic [TAG_W-1:0]     tag;
    logic [OUT_AGE_W-1:0] age;
    logic [1:0]           state;
    logic                 status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic             hit;
    logic             was_m;
    logic [TAG_W-1:0] vtag;
  } lookup_t;

endpackage

// ===== rtl/mlc_set_ram.sv =====
`timescale 1ns / 1ps

module mlc_set_ram #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mlc_way_lookup.sv =====
`timescale 1ns / 1ps

module mlc_way_lookup #(
  parameter int WAYS  = 8,
  parameter int AGE_W = 4
) (
  input  logic [WAYS-1:0][mlc_pkg::TAG_W-1:0] tags,
  input  logic [WAYS-1:0][1:0]                states,
  input  logic [WAYS-1:0][AGE_W-1:0]          ages,
  input  logic [mlc_pkg::TAG_W-1:0]           tag,
  input  logic                                alloc,
  output logic [$clog2(WAYS)-1:0]             way,
  output logic [WAYS-1:0][AGE_W-1:0]          ages_next,
  output mlc_pkg::lookup_t                    info
);
  import mlc_pkg::*;

  localparam int WW = $clog2(WAYS);

  logic signed [AGE_W-1:0] age_s [WAYS];
  logic                    hit;
  logic [WW-1:0]           hw;
  logic                    inv_found;
  logic [WW-1:0]           vw;
  logic signed [AGE_W-1:0] vmin;
  logic signed [AGE_W-1:0] old;
  logic                    pen;

  // hit search and victim choice
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      age_s[i] = signed'(ages[i]);
    end
    hit = 1'b0;
    hw  = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && tags[i] == tag && states[i] != MESI_I) begin
        hit = 1'b1;
        hw  = WW'(i);
      end
    end
    // lowest-age invalid way first, first one on a tie
    inv_found = 1'b0;
    vw        = '0;
    vmin      = age_s[0];
    for (int i = 0; i < WAYS; i++) begin
      if (states[i] == MESI_I && (!inv_found || age_s[i] < vmin)) begin
        inv_found = 1'b1;
        vw        = WW'(i);
        vmin      = age_s[i];
      end
    end
    if (!inv_found) begin
      vw   = '0;
      vmin = age_s[0];
      for (int i = 1; i < WAYS; i++) begin
        if (age_s[i] < vmin) begin
          vw   = WW'(i);
          vmin = age_s[i];
        end
      end
    end
  end

  // true-LRU promote of the touched way
  always_comb begin
    way = hit ? hw : vw;
    pen = hit || alloc;
    old = age_s[way];
    for (int i = 0; i < WAYS; i++) begin
      ages_next[i] = ages[i];
      if (pen) begin
        if (WW'(i) == way) begin
          ages_next[i] = AGE_W'(WAYS - 1);
        end else if (age_s[i] > old) begin
          ages_next[i] = ages[i] - 1'b1;
        end
      end
    end
    info.hit   = hit;
    info.was_m = !hit && alloc && states[vw] == MESI_M;
    info.vtag  = tags[vw];
  end

endmodule

// ===== rtl/mlc_result_fifo.sv =====
`timescale 1ns / 1ps

module mlc_result_fifo (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic [mlc_pkg::PUSH_W-1:0]                   push_cnt,
  input  mlc_pkg::result_t [mlc_pkg::MAX_RES-1:0]      push_data,
  output logic [mlc_pkg::RES_CNT_W-1:0]                count,
  output logic                                         res_valid,
  input  logic                                         res_stall,
  output mlc_pkg::result_t                             head
);
  import mlc_pkg::*;

  result_t              q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr;
  logic [RES_PTR_W-1:0] rptr;
  logic                 pop;

  assign res_valid = count != '0;
  assign pop       = res_valid && !res_stall;
  assign head      = q[rptr];

  // all results of a request enter in the same cycle
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (PUSH_W'(i) < push_cnt) begin
        q[wptr + RES_PTR_W'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + RES_PTR_W'(push_cnt);
      rptr  <= rptr + RES_PTR_W'(pop);
      count <= count + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop);
    end
  end

endmodule

// ===== rtl/mesi_lru_split_l1_cache_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         req_valid / req_stall     req_type, address
// result    out        res_valid / res_stall     msg_kind, msg_address, way_tag, way_age,
//                                                way_state, status, last
// config    in         APB psel/penable/pready   paddr, pwdata, prdata
//
// A request is handled thus: the set row is read from the tag RAM, then the
// lookup decides and writes the row back while all results enter the queue.
// A clear request, and reset, sweep every row of both RAMs, one row of both RAMs per
// cycle; requests are stalled meanwhile, config writes still work.
// Requests are also stalled while the result queue has room for fewer than eight.
module mesi_lru_split_l1_cache_unit #(
  parameter int DATA_SETS  = 16384,
  parameter int INSTR_SETS = 16384,
  parameter int DATA_WAYS  = 8,
  parameter int INSTR_WAYS = 4,
  parameter int LINE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [31:0] address,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  msg_kind,
  output logic [31:0] msg_address,
  output logic [11:0] way_tag,
  output logic signed [3:0] way_age,
  output logic [1:0]  way_state,
  output logic        status,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlc_pkg::*;

  localparam int OFF     = $clog2(LINE_BYTES);
  localparam int DSW     = $clog2(DATA_SETS);
  localparam int ISW     = $clog2(INSTR_SETS);
  localparam int DWW     = $clog2(DATA_WAYS);
  localparam int IWW     = $clog2(INSTR_WAYS);
  localparam int DAW     = DWW + 1;
  localparam int IAW     = IWW + 1;
  localparam int DRW     = DATA_WAYS * (TAG_W + 2 + DAW);
  localparam int IRW     = INSTR_WAYS * (TAG_W + 2 + IAW);
  localparam int MAX_SETS = (DATA_SETS > INSTR_SETS) ? DATA_SETS : INSTR_SETS;
  localparam int CW      = $clog2(MAX_SETS);
  localparam int DUMP_N  = (DATA_WAYS < MAX_RES) ? DATA_WAYS : MAX_RES;

  localparam logic [DRW-1:0] D_INIT =
    {{(DATA_WAYS * DAW){1'b1}}, {DATA_WAYS{MESI_I}}, {(DATA_WAYS * TAG_W){1'b0}}};
  localparam logic [IRW-1:0] I_INIT =
    {{(INSTR_WAYS * IAW){1'b1}}, {INSTR_WAYS{MESI_I}}, {(INSTR_WAYS * TAG_W){1'b0}}};

  ctrl_state_t state, state_next;
  logic [CW-1:0]      clr_cnt;
  logic               report_enable;
  logic [2:0]         rq_type;
  logic [ADDR_W-1:0]  rq_addr;
  logic               accept;
  logic [RES_CNT_W-1:0] fifo_cnt;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_REPORT) ? {31'b0, report_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDX_REPORT) begin
      report_enable <= pwdata[0];
    end
  end

  // request intake
  assign req_stall = !(state == S_IDLE && fifo_cnt <= RES_CNT_W'(RES_DEPTH - MAX_RES));
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      rq_type <= req_type;
      rq_addr <= address;
    end
  end

  // tag RAMs
  logic [DRW-1:0] d_rdata, d_wdata, d_row_next;
  logic [IRW-1:0] i_rdata, i_wdata, i_row_next;
  logic           d_we, i_we, d_upd, i_upd;
  logic [DSW-1:0] dset;
  logic [ISW-1:0] iset;

  assign dset = rq_addr[OFF +: DSW];
  assign iset = rq_addr[OFF +: ISW];

  assign d_we    = (state == S_CLEAR) || (state == S_LOOK && d_upd);
  assign i_we    = (state == S_CLEAR) || (state == S_LOOK && i_upd);
  assign d_wdata = (state == S_CLEAR) ? D_INIT : d_row_next;
  assign i_wdata = (state == S_CLEAR) ? I_INIT : i_row_next;

  mlc_set_ram #(.DEPTH(DATA_SETS), .WIDTH(DRW)) u_dram (
    .clk   (clk),
    .we    (d_we),
    .waddr ((state == S_CLEAR) ? clr_cnt[DSW-1:0] : dset),
    .wdata (d_wdata),
    .raddr (address[OFF +: DSW]),
    .rdata (d_rdata)
  );

  mlc_set_ram #(.DEPTH(INSTR_SETS), .WIDTH(IRW)) u_iram (
    .clk   (clk),
    .we    (i_we),
    .waddr ((state == S_CLEAR) ? clr_cnt[ISW-1:0] : iset),
    .wdata (i_wdata),
    .raddr (address[OFF +: ISW]),
    .rdata (i_rdata)
  );

  // row fields
  logic [DATA_WAYS-1:0][TAG_W-1:0]  d_tags, d_tags_n;
  logic [DATA_WAYS-1:0][1:0]        d_st, d_st_n;
  logic [DATA_WAYS-1:0][DAW-1:0]    d_age, d_age_n;
  logic [INSTR_WAYS-1:0][TAG_W-1:0] i_tags, i_tags_n;
  logic [INSTR_WAYS-1:0][1:0]       i_st, i_st_n;
  logic [INSTR_WAYS-1:0][IAW-1:0]   i_age, i_age_n;

  assign {d_age, d_st, d_tags} = d_rdata;
  assign {i_age, i_st, i_tags} = i_rdata;
  assign d_row_next = {d_age_n, d_st_n, d_tags_n};
  assign i_row_next = {i_age_n, i_st_n, i_tags_n};

  logic [TAG_W-1:0] rq_tag;
  logic             d_alloc;
  logic [DWW-1:0]   d_way;
  logic [IWW-1:0]   i_way;
  lookup_t          d_info, i_info;

  assign rq_tag  = rq_addr[TAG_LSB +: TAG_W];
  assign d_alloc = rq_type == REQ_READ || rq_type == REQ_WRITE;

  mlc_way_lookup #(.WAYS(DATA_WAYS), .AGE_W(DAW)) u_dlook (
    .tags      (d_tags),
    .states    (d_st),
    .ages      (d_age),
    .tag       (rq_tag),
    .alloc     (d_alloc),
    .way       (d_way),
    .ages_next (d_age_n),
    .info      (d_info)
  );

  mlc_way_lookup #(.WAYS(INSTR_WAYS), .AGE_W(IAW)) u_ilook (
    .tags      (i_tags),
    .states    (i_st),
    .ages      (i_age),
    .tag       (rq_tag),
    .alloc     (1'b1),
    .way       (i_way),
    .ages_next (i_age_n),
    .info      (i_info)
  );

  // decide: new line states and result list
  result_t [MAX_RES-1:0] res;
  logic [PUSH_W-1:0]     n;
  logic [ADDR_W-1:0]     vaddr;
  logic signed [DAW-1:0] dump_age;
  logic signed [7:0]     dump_ext;

  assign vaddr = {d_info.vtag, 20'b0} + (ADDR_W'(dset) << OFF);

  always_comb begin
    d_tags_n = d_tags;
    d_st_n   = d_st;
    i_tags_n = i_tags;
    i_st_n   = i_st;
    d_upd    = 1'b0;
    i_upd    = 1'b0;
    res      = '0;
    n        = '0;
    dump_age = '0;
    dump_ext = '0;
    unique case (rq_type)
      REQ_READ, REQ_WRITE: begin
        d_upd = 1'b1;
        if (d_info.hit) begin
          if (rq_type == REQ_READ) begin
            if (d_st[d_way] == MESI_E) d_st_n[d_way] = MESI_S;
          end else if (d_st[d_way] == MESI_E || d_st[d_way] == MESI_S) begin
            d_st_n[d_way] = MESI_M;
            if (report_enable) begin
              res[n[2:0]].kind = MSG_WRITE;
              res[n[2:0]].addr = rq_addr;
              n = n + 1'b1;
            end
          end
        end else begin
          d_tags_n[d_way] = rq_tag;
          d_st_n[d_way]   = (rq_type == REQ_READ) ? MESI_E : MESI_M;
          if (report_enable) begin
            if (d_info.was_m) begin
              res[n[2:0]].kind = MSG_RDATA;
              res[n[2:0]].addr = vaddr;
              n = n + 1'b1;
            end
            if (rq_type == REQ_READ) begin
              res[n[2:0]].kind = MSG_READ;
              res[n[2:0]].addr = rq_addr;
              n = n + 1'b1;
            end else begin
              res[n[2:0]].kind = MSG_WRITE;
              res[n[2:0]].addr = rq_addr;
              n = n + 1'b1;
              res[n[2:0]].kind = MSG_RFO;
              res[n[2:0]].addr = rq_addr;
              n = n + 1'b1;
            end
          end
        end
      end
      REQ_FETCH: begin
        i_upd = 1'b1;
        if (i_info.hit) begin
          if (i_st[i_way] == MESI_E) i_st_n[i_way] = MESI_S;
        end else begin
          i_tags_n[i_way] = rq_tag;
          i_st_n[i_way]   = MESI_E;
          if (report_enable) begin
            res[n[2:0]].kind = MSG_IREAD;
            res[n[2:0]].addr = rq_addr;
            n = n + 1'b1;
          end
        end
      end
      REQ_INVAL, REQ_SNOOP: begin
        d_upd = 1'b1;
        if (d_info.hit) begin
          d_st_n[d_way] = MESI_I;
          if (report_enable && d_st[d_way] == MESI_M) begin
            res[n[2:0]].kind = MSG_RDATA;
            res[n[2:0]].addr = rq_addr;
            n = n + 1'b1;
          end
        end
        if (rq_type == REQ_INVAL) begin
          res[n[2:0]].kind   = MSG_NONE;
          res[n[2:0]].addr   = rq_addr;
          res[n[2:0]].status = !d_info.hit;
          n = n + 1'b1;
        end
      end
      REQ_DUMP: begin
        for (int i = 0; i < DUMP_N; i++) begin
          dump_age        = signed'(d_age[i]);
          dump_ext        = 8'(dump_age);
          res[i].kind     = MSG_DUMP;
          res[i].addr     = rq_addr;
          res[i].tag      = d_tags[i];
          res[i].age      = dump_ext[3:0];
          res[i].state    = d_st[i];
        end
        n = PUSH_W'(DUMP_N);
      end
      default: begin
      end
    endcase
    if (n != '0) begin
      res[n[2:0] - 3'd1].last = 1'b1;
    end
  end

  // result queue
  result_t head;

  mlc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  ((state == S_LOOK) ? n : '0),
    .push_data (res),
    .count     (fifo_cnt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .head      (head)
  );

  assign msg_kind    = head.kind;
  assign msg_address = head.addr;
  assign way_tag     = head.tag;
  assign way_age     = signed'(head.age);
  assign way_state   = head.state;
  assign status      = head.status;
  assign last        = head.last;

  // control FSM
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else begin
        clr_cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_cnt == CW'(MAX_SETS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = (req_type == REQ_CLEAR) ? S_CLEAR : S_LOOK;
      end
      S_LOOK:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule
